### hdl/uvbai_pkg.sv
// ----------------------------------------------------------------------------
// uvbai_pkg
// Shared constants, types and the UV index range table for the burst
// averager.
// ----------------------------------------------------------------------------
package uvbai_pkg;

   localparam int BURST_LENGTH = 16;

   localparam int SAMPLE_W = 12;
   localparam int FS_W     = 12;
   localparam int REF_W    = 13;
   localparam int SUM_W    = 18;
   localparam int COUNT_W  = 7;
   localparam int UV_W     = 12;
   localparam int AVG_W    = 21;
   localparam int PROD_W   = SUM_W + REF_W;
   localparam int NUM_W    = PROD_W + 8;
   localparam int DEN_W    = 19;
   localparam int DIV_STEPS = AVG_W;
   localparam int STEP_W   = 5;
   localparam int RSP_W    = UV_W + AVG_W + 1 + COUNT_W;
   localparam int RSP_BYTES_W = 48;
   localparam int REQ_BYTES_W = 16;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [FS_W-1:0]  FULL_SCALE_RESET = 12'd4095;
   localparam logic [REF_W-1:0] REF_MV_RESET     = 13'd3300;

   // register select, from paddr[2]
   localparam logic REG_FULL_SCALE = 1'b0;
   localparam logic REG_REF_MV     = 1'b1;

   localparam int TABLE_SIZE = 12;
   localparam int MV_W       = 14;
   localparam logic [MV_W-1:0] TOP_MV    = 14'd1170;
   localparam logic [3:0]      TOP_INDEX = 4'd11;

   localparam logic [MV_W-1:0] RANGE_LOW [TABLE_SIZE] = '{
      14'd0,   14'd227, 14'd318, 14'd408, 14'd503,  14'd606,
      14'd696, 14'd795, 14'd881, 14'd976, 14'd1079, 14'd1170
   };
   localparam logic [MV_W-1:0] RANGE_HIGH [TABLE_SIZE] = '{
      14'd49,  14'd317, 14'd407, 14'd502, 14'd605,  14'd695,
      14'd794, 14'd880, 14'd975, 14'd1078, 14'd1169, 14'd9999
   };

   typedef struct packed {
      logic             gap;
      logic [3:0]       index;
      logic [AVG_W-1:0] lo_q8;
      logic [7:0]       den;
   } lookup_type;

   // range table search on a Q8 millivolt value
   function automatic lookup_type uv_lookup(input logic [AVG_W-1:0] v);
      lookup_type       r;
      logic             found;
      logic [AVG_W:0]   vx;
      logic [AVG_W:0]   lo_b;
      logic [AVG_W:0]   hi_b;
      logic [MV_W-1:0]  d;
      r     = '0;
      found = 1'b0;
      vx    = {1'b0, v};
      for (int i = 0; i < TABLE_SIZE; i++) begin
         lo_b = {RANGE_LOW[i], 8'b0};
         hi_b = {RANGE_HIGH[i], 8'b0};
         if (!found && vx >= lo_b && vx <= hi_b) begin
            found   = 1'b1;
            r.index = 4'(i);
         end
      end
      if (!found && vx > {TOP_MV, 8'b0}) begin
         found   = 1'b1;
         r.index = TOP_INDEX;
      end
      for (int i = 0; i < TABLE_SIZE - 1; i++) begin
         lo_b = {RANGE_HIGH[i], 8'b0};
         hi_b = {RANGE_LOW[i+1], 8'b0};
         if (!found && vx > lo_b && vx < hi_b) begin
            found   = 1'b1;
            r.index = 4'(i);
            d       = RANGE_LOW[i+1] - RANGE_HIGH[i];
            r.gap   = (d != '0);
            r.den   = d[7:0];
            r.lo_q8 = lo_b[AVG_W-1:0];
         end
      end
      return r;
   endfunction

endpackage

### hdl/uv_burst_average_index.sv
// ----------------------------------------------------------------------------
// uv_burst_average_index
// Burst averager for UV sensor samples with table-based UV index output.
//
// req channel: one 12-bit converter sample per transfer. Samples above the
// full scale register are dropped from the average but count toward the
// burst. Every BURST_LENGTH samples the block produces one rsp transfer with
// the UV index (Q8), the average in mV (Q8), a valid flag and the count of
// kept samples.
// Within a burst a sample is taken every cycle. The last sample of a burst
// starts a sequence on one multiplier and one radix-2 divider: a numerator
// multiply, a denominator multiply, a divide for the average, a table
// lookup, a divide for gap interpolation and an output step; the gap divide
// is skipped when the voltage lands in a range, and all but the output step
// when the burst is empty. req_tready is low for that time.
// The result sits in an output register; the next burst is taken while it
// waits. If it is still not taken when the next burst finishes, the block
// holds in its output step until rsp_tready.
// Reset clears the burst state, drops any pending result and restores the
// registers: full scale 4095, reference 3300 mV.
// ----------------------------------------------------------------------------
module uv_burst_average_index (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [uvbai_pkg::REQ_BYTES_W-1:0]   req_tdata,   // [11:0] adc_sample
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [11:0] uv_index_q8, [32:12] avg_millivolts_q8, [33] reading_valid,
   // [40:34] valid_samples
   output logic [uvbai_pkg::RSP_BYTES_W-1:0]   rsp_tdata,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [uvbai_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [uvbai_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [uvbai_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                                csr_pready
);
   import uvbai_pkg::*;

   typedef enum logic [6:0] {
      S_IDLE    = 7'b0000001,
      S_MUL_NUM = 7'b0000010,
      S_MUL_DEN = 7'b0000100,
      S_DIV_AVG = 7'b0001000,
      S_LOOKUP  = 7'b0010000,
      S_DIV_IDX = 7'b0100000,
      S_DONE    = 7'b1000000
   } state_type;

   state_type          state_ff, state_in;
   logic [FS_W-1:0]    fs_ff, fs_in;
   logic [REF_W-1:0]   ref_ff, ref_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [COUNT_W-1:0] seen_ff, seen_in;
   logic [COUNT_W-1:0] acc_ff, acc_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [STEP_W-1:0]  cnt_ff, cnt_in;

   logic [NUM_W-1:0]   num_ff, num_in;
   logic [DEN_W-1:0]   den_ff, den_in;
   logic [DEN_W-1:0]   rem_ff, rem_in;
   logic [AVG_W-1:0]   quo_ff, quo_in;
   logic [AVG_W-1:0]   avg_ff, avg_in;
   logic [UV_W-1:0]    idx_ff, idx_in;
   logic [RSP_W-1:0]   rsp_data_ff, rsp_data_in;

   logic [SUM_W-1:0]   mul_a;
   logic [REF_W-1:0]   mul_b;
   logic [PROD_W-1:0]  prod;
   logic [DEN_W:0]     shifted;
   logic [DEN_W:0]     diff;
   logic               q_bit;
   logic [DEN_W-1:0]   rem_next;
   logic [AVG_W-1:0]   quo_next;
   lookup_type         lookup;

   logic [SAMPLE_W-1:0] sample;
   logic               take;
   logic [SUM_W-1:0]   sum_new;
   logic [COUNT_W-1:0] acc_new;
   logic [COUNT_W-1:0] seen_new;
   logic [AVG_W-1:0]   gap_num;
   logic               csr_write;

   // shared multiplier
   always_comb begin
      if (state_ff == S_MUL_DEN) begin
         mul_a = {{(SUM_W-FS_W){1'b0}}, fs_ff};
         mul_b = {{(REF_W-COUNT_W){1'b0}}, acc_ff};
      end else begin
         mul_a = sum_ff;
         mul_b = ref_ff;
      end
   end
   assign prod = {{REF_W{1'b0}}, mul_a} * {{SUM_W{1'b0}}, mul_b};

   // shared restoring divider step
   assign shifted  = {rem_ff, quo_ff[AVG_W-1]};
   assign diff     = shifted - {1'b0, den_ff};
   assign q_bit    = (shifted >= {1'b0, den_ff});
   assign rem_next = q_bit ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
   assign quo_next = {quo_ff[AVG_W-2:0], q_bit};

   assign lookup  = uv_lookup(avg_ff);
   assign gap_num = avg_ff - lookup.lo_q8;

   assign sample   = req_tdata[SAMPLE_W-1:0];
   assign take     = (sample <= fs_ff);
   assign sum_new  = take ? sum_ff + {{(SUM_W-SAMPLE_W){1'b0}}, sample} : sum_ff;
   assign acc_new  = take ? acc_ff + 1'b1 : acc_ff;
   assign seen_new = seen_ff + 1'b1;

   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      state_in     = state_ff;
      sum_in       = sum_ff;
      seen_in      = seen_ff;
      acc_in       = acc_ff;
      cnt_in       = cnt_ff;
      num_in       = num_ff;
      den_in       = den_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      avg_in       = avg_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      fs_in        = fs_ff;
      ref_in       = ref_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               sum_in = sum_new;
               acc_in = acc_new;
               if (seen_new == COUNT_W'(BURST_LENGTH)) begin
                  seen_in = '0;
                  if (acc_new == '0) begin
                     avg_in   = '0;
                     idx_in   = '0;
                     state_in = S_DONE;
                  end else begin
                     state_in = S_MUL_NUM;
                  end
               end else begin
                  seen_in = seen_new;
               end
            end
         end
         S_MUL_NUM: begin
            num_in   = {prod[NUM_W-9:0], 8'b0};
            state_in = S_MUL_DEN;
         end
         S_MUL_DEN: begin
            den_in = prod[DEN_W-1:0];
            if (prod[DEN_W-1:0] == '0) begin
               avg_in   = '0;
               state_in = S_LOOKUP;
            end else begin
               rem_in   = {{(DEN_W-(NUM_W-AVG_W)){1'b0}}, num_ff[NUM_W-1:AVG_W]};
               quo_in   = num_ff[AVG_W-1:0];
               cnt_in   = STEP_W'(DIV_STEPS);
               state_in = S_DIV_AVG;
            end
         end
         S_DIV_AVG: begin
            rem_in = rem_next;
            quo_in = quo_next;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == STEP_W'(1)) begin
               avg_in   = quo_next;
               state_in = S_LOOKUP;
            end
         end
         S_LOOKUP: begin
            idx_in = {lookup.index, 8'b0};
            if (lookup.gap) begin
               rem_in   = '0;
               quo_in   = gap_num;
               den_in   = {{(DEN_W-8){1'b0}}, lookup.den};
               cnt_in   = STEP_W'(DIV_STEPS);
               state_in = S_DIV_IDX;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DIV_IDX: begin
            rem_in = rem_next;
            quo_in = quo_next;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == STEP_W'(1)) begin
               idx_in   = {idx_ff[UV_W-1:8], quo_next[7:0]};
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {acc_ff, (acc_ff != '0), avg_ff, idx_ff};
               sum_in       = '0;
               acc_in       = '0;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (csr_write) begin
         unique case (csr_paddr[2])
            REG_FULL_SCALE: fs_in  = csr_pwdata[FS_W-1:0];
            REG_REF_MV:     ref_in = csr_pwdata[REF_W-1:0];
            default:        fs_in  = fs_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fs_ff        <= FULL_SCALE_RESET;
         ref_ff       <= REF_MV_RESET;
         sum_ff       <= '0;
         seen_ff      <= '0;
         acc_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fs_ff        <= fs_in;
         ref_ff       <= ref_in;
         sum_ff       <= sum_in;
         seen_ff      <= seen_in;
         acc_ff       <= acc_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff      <= num_in;
      den_ff      <= den_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      avg_ff      <= avg_in;
      idx_ff      <= idx_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_BYTES_W-RSP_W){1'b0}}, rsp_data_ff};

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_REF_MV) ?
                       {{(CSR_DATA_W-REF_W){1'b0}}, ref_ff} :
                       {{(CSR_DATA_W-FS_W){1'b0}}, fs_ff};

endmodule

### hdl/uvbai_checker.sv
// ----------------------------------------------------------------------------
// uvbai_checker
// Port-level checks for the UV burst averager, bound to the top level.
// ----------------------------------------------------------------------------
module uvbai_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [uvbai_pkg::RSP_BYTES_W-1:0] rsp_tdata
);
   import uvbai_pkg::*;

   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid set after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   a_empty_burst_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[33] |->
         rsp_tdata[11:0] == '0 && rsp_tdata[32:12] == '0 && rsp_tdata[40:34] == '0)
      else $error("empty burst result not zero");

   a_count_consistent: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[33] == (rsp_tdata[40:34] != '0) &&
         rsp_tdata[40:34] <= COUNT_W'(BURST_LENGTH) && rsp_tdata[11:0] <= 12'd2816)
      else $error("result count or index out of range");

endmodule

bind uv_burst_average_index uvbai_checker u_uvbai_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

### dv/uv_burst_average_index_tb.sv
// ----------------------------------------------------------------------------
// uv_burst_average_index_tb
// Self-checking bench for the UV burst averager. A directed table of bursts
// covers reset values, extreme samples and registers, empty bursts, zero full
// scale and the range and gap cases of the UV table. Random bursts follow
// under several register settings. Every result transfer is checked field by
// field against the directed table or a behavioral predictor, with random
// sender gaps and receiver stalls and one long hold-off that backs up the input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module uv_burst_average_index_tb;

   import uvbai_pkg::*;

   localparam int RESET_CYCLES     = 8;
   localparam int SETTLE_CYCLES    = 64;
   localparam int CYCLE_LIMIT      = 400000;
   localparam int HOLD_CYCLES      = 600;
   localparam int RANDOM_PHASES    = 8;
   localparam int BURSTS_PER_PHASE = 3;
   localparam int DIRECTED_ROWS    = 14;

   localparam logic [CSR_ADDR_W-1:0] ADDR_FULL_SCALE = {REG_FULL_SCALE, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] ADDR_REF_MV     = {REG_REF_MV, 2'b00};

   // UV index bands in mV: index, low edge, high edge
   localparam int BAND_COUNT = 12;
   localparam int unsigned BAND_LOW_MV [BAND_COUNT] = '{
      0, 227, 318, 408, 503, 606, 696, 795, 881, 976, 1079, 1170
   };
   localparam int unsigned BAND_HIGH_MV [BAND_COUNT] = '{
      49, 317, 407, 502, 605, 695, 794, 880, 975, 1078, 1169, 9999
   };
   localparam int unsigned BAND_TOP_MV    = 1170;
   localparam int unsigned BAND_TOP_INDEX = 11;

   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic               valid;
      logic [AVG_W-1:0]   avg_mv;
      logic [UV_W-1:0]    uv;
   } burst_result_type;

   typedef struct {
      logic [FS_W-1:0]     full_scale;
      logic [REF_W-1:0]    ref_mv;
      logic [SAMPLE_W-1:0] even_sample;
      logic [SAMPLE_W-1:0] odd_sample;
      bit                  typed;
      burst_result_type    want;
   } burst_row_type;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_BYTES_W-1:0] req_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_BYTES_W-1:0] rsp_tdata;
   logic                   csr_psel;
   logic                   csr_penable;
   logic                   csr_pwrite;
   logic [CSR_ADDR_W-1:0]  csr_paddr;
   logic [CSR_DATA_W-1:0]  csr_pwdata;
   logic [CSR_DATA_W-1:0]  csr_prdata;
   logic                   csr_pready;

   // predictor state
   logic [FS_W-1:0]    cur_full_scale;
   logic [REF_W-1:0]   cur_ref_mv;
   logic [SUM_W-1:0]   burst_sum;
   logic [COUNT_W-1:0] burst_seen;
   logic [COUNT_W-1:0] burst_kept;

   burst_result_type pending_results [$];
   int               error_count = 0;
   int               cycle_count = 0;
   int               run_left;
   bit               hold_request;

   burst_row_type burst_table [DIRECTED_ROWS] = '{
      '{12'd4095, 13'd3300, 12'd0,    12'd0,    1'b1,
        '{count: 7'd16, valid: 1'b1, avg_mv: 21'd0,       uv: 12'd0}},
      '{12'd4095, 13'd3300, 12'd4095, 12'd4095, 1'b1,
        '{count: 7'd16, valid: 1'b1, avg_mv: 21'd844800,  uv: 12'd2816}},
      '{12'd100,  13'd3300, 12'd4095, 12'd101,  1'b1,
        '{count: 7'd0,  valid: 1'b0, avg_mv: 21'd0,       uv: 12'd0}},
      '{12'd0,    13'd3300, 12'd0,    12'd1,    1'b1,
        '{count: 7'd8,  valid: 1'b1, avg_mv: 21'd0,       uv: 12'd0}},
      '{12'd4095, 13'd8191, 12'd4095, 12'd4095, 1'b1,
        '{count: 7'd16, valid: 1'b1, avg_mv: 21'd2096896, uv: 12'd2816}},
      '{12'd4095, 13'd0,    12'd4095, 12'd4095, 1'b1,
        '{count: 7'd16, valid: 1'b1, avg_mv: 21'd0,       uv: 12'd0}},
      '{12'd1000, 13'd1000, 12'd49,   12'd49,   1'b0, '0},
      '{12'd1000, 13'd1000, 12'd100,  12'd100,  1'b0, '0},
      '{12'd1000, 13'd1000, 12'd317,  12'd318,  1'b0, '0},
      '{12'd1000, 13'd1000, 12'd226,  12'd227,  1'b0, '0},
      '{12'd1000, 13'd1000, 12'd1169, 12'd1170, 1'b0, '0},
      '{12'd1000, 13'd1000, 12'd1170, 12'd1170, 1'b0, '0},
      '{12'd1,    13'd5000, 12'd1,    12'd2,    1'b0, '0},
      '{12'd4095, 13'd3300, 12'd0,    12'd4095, 1'b0, '0}
   };

   uv_burst_average_index u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles", $time, cycle_count);
         $display("Test completed with failures");
         $finish;
      end
   end

   // Q8 millivolts to Q8 UV index
   function automatic logic [UV_W-1:0] uv_index_q8_of(input longint unsigned mv_q8);
      longint unsigned lo;
      longint unsigned hi;
      longint unsigned den;
      for (int i = 0; i < BAND_COUNT; i++) begin
         if (mv_q8 >= BAND_LOW_MV[i] * 256 && mv_q8 <= BAND_HIGH_MV[i] * 256)
            return UV_W'(i * 256);
      end
      if (mv_q8 > BAND_TOP_MV * 256)
         return UV_W'(BAND_TOP_INDEX * 256);
      for (int i = 0; i < BAND_COUNT - 1; i++) begin
         lo = BAND_HIGH_MV[i] * 256;
         hi = BAND_LOW_MV[i+1] * 256;
         if (mv_q8 > lo && mv_q8 < hi) begin
            den = BAND_LOW_MV[i+1] - BAND_HIGH_MV[i];
            if (den == 0)
               return UV_W'(i * 256);
            return UV_W'(i * 256 + (mv_q8 - lo) / den);
         end
      end
      return '0;
   endfunction

   // folds one sample into the burst; returns 1 with the result at burst end
   function automatic bit accumulate_sample(input logic [SAMPLE_W-1:0] sample,
                                            output burst_result_type r);
      longint unsigned den;
      longint unsigned avg;
      r   = '0;
      avg = 0;
      if (sample <= cur_full_scale) begin
         burst_sum  = burst_sum + sample;
         burst_kept = burst_kept + 1'b1;
      end
      burst_seen = burst_seen + 1'b1;
      if (burst_seen < BURST_LENGTH)
         return 1'b0;
      if (burst_kept != 0) begin
         den = longint'(cur_full_scale) * burst_kept;
         if (den != 0)
            avg = (longint'(burst_sum) * cur_ref_mv * 256) / den;
         r.uv = uv_index_q8_of(avg);
      end
      r.avg_mv   = avg[AVG_W-1:0];
      r.valid    = (burst_kept != 0);
      r.count    = burst_kept;
      burst_sum  = '0;
      burst_seen = '0;
      burst_kept = '0;
      return 1'b1;
   endfunction

   function automatic void check_field(input string name, input longint unsigned want,
                                       input longint unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         error_count++;
      end
   endfunction

   task automatic send_sample(input logic [SAMPLE_W-1:0] sample, input bit typed,
                              input burst_result_type typed_result);
      int               gap;
      burst_result_type r;
      if (run_left == 0) begin
         run_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(1, 12);
         gap = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 3);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_BYTES_W'(sample);
      do @(posedge clock); while (!req_tready);
      run_left--;
      if (accumulate_sample(sample, r))
         pending_results.push_back(typed ? typed_result : r);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic set_config(input logic [FS_W-1:0] full_scale,
                             input logic [REF_W-1:0] ref_mv);
      wait_idle();
      if (full_scale != cur_full_scale) begin
         csr_write(ADDR_FULL_SCALE, CSR_DATA_W'(full_scale));
         cur_full_scale = full_scale;
      end
      if (ref_mv != cur_ref_mv) begin
         csr_write(ADDR_REF_MV, CSR_DATA_W'(ref_mv));
         cur_ref_mv = ref_mv;
      end
   endtask

   // result side: checks transfers, stalls on its own pattern
   initial begin : rsp_side
      int               mode;
      int               mode_left;
      int               hold_left;
      bit               hold_done;
      bit               next_ready;
      burst_result_type got;
      burst_result_type want;
      mode       = 0;
      mode_left  = 0;
      hold_left  = 0;
      hold_done  = 1'b0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[RSP_W-1:0];
            if (pending_results.size() == 0) begin
               $display("%0t: unexpected result transfer, expected none, actual %h",
                        $time, got);
               error_count++;
            end else begin
               want = pending_results.pop_front();
               check_field("uv_index_q8", want.uv, got.uv);
               check_field("avg_millivolts_q8", want.avg_mv, got.avg_mv);
               check_field("reading_valid", want.valid, got.valid);
               check_field("valid_samples", want.count, got.count);
            end
         end
         if (hold_request && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            next_ready = 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode      = $urandom_range(0, 3);
               mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            case (mode)
               0: next_ready = 1'b1;
               1: next_ready = $urandom_range(0, 1);
               2: next_ready = ($urandom_range(0, 3) == 0);
               default: next_ready = ($urandom_range(0, 15) != 0) ? rsp_tready : !rsp_tready;
            endcase
         end
         rsp_tready <= next_ready;
      end
   end

   initial begin : req_side
      logic [FS_W-1:0]     fs_next;
      logic [REF_W-1:0]    mv_next;
      logic [SAMPLE_W-1:0] base;
      logic [SAMPLE_W-1:0] sample;
      int                  shape;
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      run_left     = 0;
      hold_request = 1'b0;
      cur_full_scale = FULL_SCALE_RESET;
      cur_ref_mv     = REF_MV_RESET;
      burst_sum      = '0;
      burst_seen     = '0;
      burst_kept     = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (burst_table[r]) begin
         if (burst_table[r].full_scale != cur_full_scale ||
             burst_table[r].ref_mv != cur_ref_mv)
            set_config(burst_table[r].full_scale, burst_table[r].ref_mv);
         for (int k = 0; k < BURST_LENGTH; k++)
            send_sample(k % 2 ? burst_table[r].odd_sample : burst_table[r].even_sample,
                        burst_table[r].typed, burst_table[r].want);
      end

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0: begin
               fs_next = $urandom_range(1, 4095);
               mv_next = $urandom_range(1, 5000);
            end
            1: begin
               fs_next = $urandom_range(200, 1400);
               mv_next = REF_W'(fs_next);
            end
            2: begin
               fs_next = 12'd4095;
               mv_next = 13'd5000;
            end
            3: begin
               fs_next = 12'd1;
               mv_next = 13'd8191;
            end
            4: begin
               fs_next = 12'd0;
               mv_next = $urandom_range(0, 8191);
            end
            5: begin
               fs_next = $urandom_range(0, 4095);
               mv_next = $urandom_range(0, 8191);
            end
            6: begin
               fs_next = 12'd1000;
               mv_next = 13'd1000;
            end
            default: begin
               fs_next = FULL_SCALE_RESET;
               mv_next = REF_MV_RESET;
            end
         endcase
         set_config(fs_next, mv_next);
         // receiver holds off while this phase streams, backing up the input
         if (p == 2)
            hold_request = 1'b1;
         for (int b = 0; b < BURSTS_PER_PHASE; b++) begin
            shape = $urandom_range(0, 9);
            base  = $urandom_range(0, fs_next);
            for (int k = 0; k < BURST_LENGTH; k++) begin
               case (shape)
                  0, 1: sample = $urandom_range(0, 4095);
                  2, 3, 4: sample = $urandom_range(0, fs_next);
                  5: begin
                     if (fs_next == 12'd4095 || $urandom_range(0, 7) == 0)
                        sample = $urandom_range(0, 4095);
                     else
                        sample = $urandom_range(fs_next + 1, 4095);
                  end
                  6, 7, 8: sample = (base == 12'd4095) ? base
                                                        : base + $urandom_range(0, 1);
                  default: begin
                     case ($urandom_range(0, 3))
                        0: sample = '0;
                        1: sample = fs_next;
                        2: sample = (fs_next == 12'd4095) ? fs_next : fs_next + 1'b1;
                        default: sample = 12'd4095;
                     endcase
                  end
               endcase
               send_sample(sample, 1'b0, '0);
            end
         end
      end

      wait_idle();
      if (error_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
